### hw/rtl/gbr_pkg.sv
// Shared types and constants of the bitmap glyph row renderer.
// No dependencies; every other file of the block except gbr_ram imports this package.
`default_nettype none

package gbr_pkg;

    // Font geometry
    localparam int NUM_GLYPHS       = 256;
    localparam int MAX_GLYPH_WIDTH  = 16;
    localparam int MAX_GLYPH_HEIGHT = 16;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int ROW_W    = 4;
    localparam int BITS_W   = 16;
    localparam int OFFS_W   = 4;
    localparam int COLOR_W  = 24;
    localparam int COL_W    = 4;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;

    // Glyph store: one row word per character and row
    localparam int STORE_DEPTH = NUM_GLYPHS * MAX_GLYPH_HEIGHT;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 5'd8;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 5'd16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GLYPH_WIDTH  = 1'b0,
        REG_GLYPH_HEIGHT = 1'b1
    } t_cfg_idx;

    // Item opcodes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } t_op;

    // Back end sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } t_back_state;

    // Classified command passed from the front end to the back end
    typedef struct packed {
        t_op                 op;
        logic [STORE_AW-1:0] addr;
        logic [BITS_W-1:0]   bits;    // shifted, width-masked load word
        logic [CFG_W-1:0]    width;   // effective glyph width, 1..16
        logic [COLOR_W-1:0]  fg;
        logic [COLOR_W-1:0]  bg;
        logic                opaque;
    } t_cmd;

    // One pixel beat
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               we;
        logic [COL_W-1:0]   column;
        logic               last;
    } t_pix;

endpackage

`default_nettype wire

### hw/rtl/gbr_if.sv
// Valid/ready channel interfaces of the glyph renderer: item input and pixel output.
// Depends on gbr_pkg for the field widths.
`default_nettype none

interface gbr_item_if;
    import gbr_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [CHAR_W-1:0]   char_code;
    logic [ROW_W-1:0]    glyph_row;
    logic [BITS_W-1:0]   row_bits;
    logic [OFFS_W-1:0]   column_offset;
    logic [COLOR_W-1:0]  fg_color;
    logic [COLOR_W-1:0]  bg_color;
    logic                opaque;

    modport source (
        output valid, op, char_code, glyph_row, row_bits, column_offset,
               fg_color, bg_color, opaque,
        input  ready
    );
    modport sink (
        input  valid, op, char_code, glyph_row, row_bits, column_offset,
               fg_color, bg_color, opaque,
        output ready
    );
endinterface

interface gbr_pix_if;
    import gbr_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic               write_enable;
    logic [COL_W-1:0]   pixel_column;
    logic               last;

    modport source (
        output valid, pixel_color, write_enable, pixel_column, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, write_enable, pixel_column, last,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/gbr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/gbr_front.sv
// Front end: configuration registers, item intake and classification into commands.
// Depends on gbr_pkg and the gbr_item_if interface.
`default_nettype none

module gbr_front import gbr_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_clearing,
    input  wire logic                 i_q_full,
    gbr_item_if.sink                  i_item,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic [CFG_W-1:0]  eff_width;
    logic [CFG_W-1:0]  eff_height;
    logic [BITS_W-1:0] rev_bits;
    logic [BITS_W-1:0] shifted;
    logic [BITS_W:0]   width_mask;
    logic              row_ok;
    logic              accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_GLYPH_WIDTH:  r_width  <= i_cfg_data;
                REG_GLYPH_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp width and height into 1..max
    always_comb begin
        if (r_width == '0) begin
            eff_width = CFG_W'(1);
        end else if (r_width > CFG_W'(MAX_GLYPH_WIDTH)) begin
            eff_width = CFG_W'(MAX_GLYPH_WIDTH);
        end else begin
            eff_width = r_width;
        end
        if (r_height == '0) begin
            eff_height = CFG_W'(1);
        end else if (r_height > CFG_W'(MAX_GLYPH_HEIGHT)) begin
            eff_height = CFG_W'(MAX_GLYPH_HEIGHT);
        end else begin
            eff_height = r_height;
        end
    end

    // Build the load word: MSB-first bits become column order, shift right, drop spill
    always_comb begin
        for (int c = 0; c < BITS_W; c++) begin
            rev_bits[c] = i_item.row_bits[BITS_W-1-c];
        end
        shifted    = rev_bits << i_item.column_offset;
        width_mask = ((BITS_W+1)'(1) << eff_width) - (BITS_W+1)'(1);
    end

    assign row_ok = {1'b0, i_item.glyph_row} < eff_height;

    // Take an item whenever the queue has room and the store is cleared
    assign i_item.ready = !i_clearing && !i_q_full;
    assign accept       = i_item.valid && i_item.ready;

    // Drop items whose row lies past the glyph height
    assign o_push = accept && row_ok;

    always_comb begin
        o_cmd.op     = t_op'(i_item.op);
        o_cmd.addr   = {i_item.char_code, i_item.glyph_row};
        o_cmd.bits   = shifted & width_mask[BITS_W-1:0];
        o_cmd.width  = eff_width;
        o_cmd.fg     = i_item.fg_color;
        o_cmd.bg     = i_item.bg_color;
        o_cmd.opaque = i_item.opaque;
    end

endmodule

`default_nettype wire

### hw/rtl/gbr_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on gbr_pkg for the command type.
`default_nettype none

module gbr_queue import gbr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_slot[r_rd_ptr];

    // Never overfill or underrun the queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("command queue pushed while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command queue popped while empty");

endmodule

`default_nettype wire

### hw/rtl/gbr_back.sv
// Back end: glyph store clearing, load read-modify-write and pixel emission.
// Depends on gbr_pkg, gbr_pix_if and gbr_ram.
`default_nettype none

module gbr_back import gbr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_clearing,
    gbr_pix_if.source o_pix
);

    t_back_state         r_state;
    t_back_state         n_state;
    logic [STORE_AW-1:0] r_clr_addr;
    logic [STORE_AW-1:0] n_clr_addr;
    t_cmd                r_cmd;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_col;
    logic                r_out_valid;
    logic                n_out_valid;
    t_pix                r_out;
    t_pix                pix;
    logic                out_load;
    logic                pix_set;

    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [BITS_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [BITS_W-1:0]   ram_rdata;

    gbr_ram #(
        .WIDTH (BITS_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_cmd.addr),
        .o_rdata (ram_rdata)
    );

    // Pixel for the current column; the read word holds until the next fetch
    always_comb begin
        pix_set    = ram_rdata[r_col];
        pix.column = r_col;
        pix.last   = ({1'b0, r_col} + CFG_W'(1)) == r_cmd.width;
        if (r_cmd.opaque) begin
            pix.color = pix_set ? r_cmd.fg : r_cmd.bg;
            pix.we    = 1'b1;
        end else begin
            pix.color = pix_set ? r_cmd.fg : '0;
            pix.we    = pix_set;
        end
    end

    // Sequencer: next state, store access and output load
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_col      = r_col;
        ram_we     = 1'b0;
        ram_waddr  = r_cmd.addr;
        ram_wdata  = ram_rdata | r_cmd.bits;
        ram_re     = 1'b0;
        o_cmd_pop  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + STORE_AW'(1);
                if (r_clr_addr == STORE_AW'(STORE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    ram_re    = 1'b1;
                    o_cmd_pop = 1'b1;
                    n_state   = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_col = '0;
                if (r_cmd.op == OP_LOAD) begin
                    ram_we  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_pix.ready) begin
                    out_load = 1'b1;
                    n_col    = r_col + COL_W'(1);
                    if (pix.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output register valid: set on load, drop when taken
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (out_load) begin
            r_out <= pix;
        end
    end

    assign o_clearing         = r_state == ST_CLEAR;
    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_color  = r_out.color;
    assign o_pix.write_enable = r_out.we;
    assign o_pix.pixel_column = r_out.column;
    assign o_pix.last         = r_out.last;

    // No pixel leaves while the store is being cleared
    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !r_out_valid)
        else $error("pixel output during store clear");
    // A row restarts at column zero after its last beat
    a_row_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && o_pix.ready && o_pix.last
        |=> !o_pix.valid || o_pix.pixel_column == '0)
        else $error("row did not restart at column zero");
    // Columns of a row advance by one per beat
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && o_pix.ready && !o_pix.last
        |=> !o_pix.valid || o_pix.pixel_column == $past(o_pix.pixel_column) + COL_W'(1))
        else $error("pixel column skipped");

endmodule

`default_nettype wire

### hw/rtl/bitmap_glyph_row_renderer.sv
// Top level of the bitmap glyph row renderer: front end, command queue, back end.
// Depends on gbr_pkg, gbr_if, gbr_front, gbr_queue and gbr_back.
//
// Character generator for monospaced bitmap fonts with a 256 x 16 row glyph store.
// After reset the store is swept to zero, one row word per cycle, over all 4096 words;
// no item is taken during that sweep, configuration writes are. A load item ORs a
// shifted, width-trimmed row word into the store and occupies the back end for a
// store read, then a write. A draw item likewise reads its row word first and then
// emits one pixel beat per cycle while the pixel output is ready. Items whose row is
// at or past glyph_height are accepted and produce nothing. A two-entry queue lets
// intake run ahead of pixel emission.
`default_nettype none

module bitmap_glyph_row_renderer import gbr_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    gbr_item_if.sink                  i_item,
    gbr_pix_if.source                 o_pix
);

    logic clearing;
    logic q_full;
    logic push;
    t_cmd push_cmd;
    logic pop;
    logic head_valid;
    t_cmd head_cmd;

    gbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_clearing  (clearing),
        .i_q_full    (q_full),
        .i_item      (i_item),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    gbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    gbr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .o_clearing  (clearing),
        .o_pix       (o_pix)
    );

endmodule

`default_nettype wire
